@@ rtl/est_pkg.sv @@
// ----------------------------------------------------------------------------
// est_pkg
// Shared field widths, saturation limits and the command and status bundles
// that pass between the tour search controller and its datapath.
// ----------------------------------------------------------------------------
package est_pkg;

  // Fixed widths of the channel fields.
  localparam int CITY_FIELD_W = 3;
  localparam int EDGE_W       = 32;
  localparam int TOTAL_W      = 35;
  localparam int CFG_W        = 4;

  // Limits of the signed tour total.
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 35'sh3_FFFF_FFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 35'sh4_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_search;
    logic tour_start;
    logic edge_rd;
    logic edge_acc;
    logic find_pivot;
    logic swap_pivot;
    logic rev_step;
    logic emit;
  } est_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tour_end;
    logic pivot_none;
    logic rev_done;
    logic emit_last;
    logic out_free;
  } est_sts_t;

endpackage

@@ rtl/est_in_if.sv @@
// ----------------------------------------------------------------------------
// est_in_if
// Input channel: one cost matrix entry per transfer.
// ----------------------------------------------------------------------------
interface est_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [est_pkg::CITY_FIELD_W-1:0]       from_city;
  logic [est_pkg::CITY_FIELD_W-1:0]       to_city;
  logic signed [est_pkg::EDGE_W-1:0]      edge_cost;
  logic                                   last_entry;

  modport source (output valid, from_city, to_city, edge_cost, last_entry, input ready);
  modport sink   (input valid, from_city, to_city, edge_cost, last_entry, output ready);
endinterface

@@ rtl/est_out_if.sv @@
// ----------------------------------------------------------------------------
// est_out_if
// Result channel: one city of the best tour per transfer.
// ----------------------------------------------------------------------------
interface est_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [est_pkg::CITY_FIELD_W-1:0]       tour_city;
  logic signed [est_pkg::TOTAL_W-1:0]     best_cost;
  logic                                   is_last;

  modport source (output valid, tour_city, best_cost, is_last, input ready);
  modport sink   (input valid, tour_city, best_cost, is_last, output ready);
endinterface

@@ rtl/est_ctrl.sv @@
// ----------------------------------------------------------------------------
// est_ctrl
// Sequencer of the search: loading, tour summation, lexicographic advance
// of the ordering and emission of the best tour.
// ----------------------------------------------------------------------------
module est_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_last,
  input  est_pkg::est_sts_t sts,
  output est_pkg::est_cmd_t cmd,
  output logic              in_ready
);
  import est_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_RD, S_ACC, S_PIV, S_SWP, S_REV, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.start_search = 1'b1;
        state_nxt        = S_RD;
      end
      S_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.edge_acc = 1'b1;
        state_nxt    = sts.tour_end ? S_PIV : S_RD;
      end
      S_PIV: begin
        cmd.find_pivot = 1'b1;
        state_nxt      = sts.pivot_none ? S_EMIT : S_SWP;
      end
      S_SWP: begin
        cmd.swap_pivot = 1'b1;
        state_nxt      = S_REV;
      end
      S_REV: begin
        if (sts.rev_done) begin
          cmd.tour_start = 1'b1;
          state_nxt      = S_RD;
        end else begin
          cmd.rev_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

@@ rtl/est_dpath.sv @@
// ----------------------------------------------------------------------------
// est_dpath
// Cost matrix memory, current and best orderings, saturating tour adder,
// next-permutation logic and the result register.
// ----------------------------------------------------------------------------
module est_dpath #(
  parameter int MAX_CITIES = 8,
  parameter int COST_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  est_pkg::est_cmd_t                       cmd,
  output est_pkg::est_sts_t                       sts,
  input  logic [est_pkg::CFG_W-1:0]               num_cities,
  input  logic                                    wr_en,
  input  logic [est_pkg::CITY_FIELD_W-1:0]        wr_from,
  input  logic [est_pkg::CITY_FIELD_W-1:0]        wr_to,
  input  logic signed [est_pkg::EDGE_W-1:0]       wr_cost,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [est_pkg::CITY_FIELD_W-1:0]        out_tour_city,
  output logic signed [est_pkg::TOTAL_W-1:0]      out_best_cost,
  output logic                                    out_is_last
);
  import est_pkg::*;

  localparam int CITY_W = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = ((COST_BITS > TOTAL_W) ? COST_BITS : TOTAL_W) + 1;

  logic signed [COST_BITS-1:0] mem [DEPTH];
  logic signed [COST_BITS-1:0] rd_data_r;

  logic [CITY_W-1:0] order_r      [MAX_CITIES];
  logic [CITY_W-1:0] best_order_r [MAX_CITIES];
  logic [CNT_W-1:0]  n_r, n_c, ek_r;
  logic [CITY_W-1:0] k_r, k_nx, piv_r, piv_c, j_c, lo_r, hi_r, last_idx, e_idx;
  logic signed [TOTAL_W-1:0] best_r, partial_r, sum_sat;
  logic signed [SUM_W-1:0]   sum_w;
  logic signed [63:0]        cost_wide;
  logic signed [COST_BITS-1:0] cost_sat;
  logic              have_best_r, piv_found, prune, edge_last, keep;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              out_valid_r, out_is_last_r;
  logic [CITY_FIELD_W-1:0]   out_city_r;
  logic signed [TOTAL_W-1:0] out_cost_r;

  // City count taken from the register, clamped to the supported range.
  always_comb begin
    if (num_cities < CFG_W'(2))                n_c = CNT_W'(2);
    else if (32'(num_cities) > MAX_CITIES)     n_c = CNT_W'(MAX_CITIES);
    else                                       n_c = CNT_W'(num_cities);
  end

  assign last_idx = CITY_W'(n_r - CNT_W'(1));

  // Entry saturation to the stored width.
  always_comb begin
    cost_wide = 64'(wr_cost);
    if (COST_BITS >= EDGE_W) begin
      cost_sat = COST_BITS'(cost_wide);
    end else if (cost_wide > (64'sd1 <<< (COST_BITS - 1)) - 64'sd1) begin
      cost_sat = COST_BITS'((64'sd1 <<< (COST_BITS - 1)) - 64'sd1);
    end else if (cost_wide < -(64'sd1 <<< (COST_BITS - 1))) begin
      cost_sat = COST_BITS'(-(64'sd1 <<< (COST_BITS - 1)));
    end else begin
      cost_sat = COST_BITS'(cost_wide);
    end
  end

  assign wr_ok   = (32'(wr_from) < MAX_CITIES) && (32'(wr_to) < MAX_CITIES);
  assign wr_addr = ADDR_W'(32'(wr_from) * MAX_CITIES + 32'(wr_to));
  assign k_nx    = (k_r == last_idx) ? '0 : CITY_W'(k_r + CITY_W'(1));
  assign rd_addr = ADDR_W'(32'(order_r[k_r]) * MAX_CITIES + 32'(order_r[k_nx]));

  // Cost matrix: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) mem[wr_addr] <= cost_sat;
    if (cmd.edge_rd)    rd_data_r    <= mem[rd_addr];
  end

  // Saturating accumulation of one edge and the prune decision.
  always_comb begin
    sum_w = SUM_W'(partial_r) + SUM_W'(rd_data_r);
    if (sum_w > SUM_W'(TOTAL_MAX))      sum_sat = TOTAL_MAX;
    else if (sum_w < SUM_W'(TOTAL_MIN)) sum_sat = TOTAL_MIN;
    else                                sum_sat = TOTAL_W'(sum_w);
  end

  assign prune     = have_best_r && (sum_sat > best_r);
  assign edge_last = (k_r == last_idx);
  assign keep      = edge_last && !prune && (!have_best_r || (sum_sat < best_r));

  // Pivot: last rising pair of the ordering.
  always_comb begin
    piv_found = 1'b0;
    piv_c     = '0;
    for (int i = 1; i < MAX_CITIES; i++) begin
      if ((i < 32'(n_r)) && (order_r[i-1] < order_r[i])) begin
        piv_found = 1'b1;
        piv_c     = CITY_W'(i - 1);
      end
    end
  end

  // Swap partner: last city after the pivot that is larger than it.
  always_comb begin
    j_c = '0;
    for (int j = 0; j < MAX_CITIES; j++) begin
      if ((j < 32'(n_r)) && (order_r[j] > order_r[piv_r])) j_c = CITY_W'(j);
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      n_r       <= n_c;
      best_r    <= TOTAL_MAX;
      partial_r <= '0;
      k_r       <= '0;
      ek_r      <= '0;
      for (int i = 0; i < MAX_CITIES; i++) order_r[i] <= CITY_W'(i);
    end
    if (cmd.tour_start) begin
      partial_r <= '0;
      k_r       <= '0;
    end
    if (cmd.edge_acc) begin
      partial_r <= sum_sat;
      k_r       <= k_nx;
      if (keep) begin
        best_r       <= sum_sat;
        best_order_r <= order_r;
      end
    end
    if (cmd.find_pivot) piv_r <= piv_c;
    if (cmd.swap_pivot) begin
      order_r[piv_r] <= order_r[j_c];
      order_r[j_c]   <= order_r[piv_r];
      lo_r           <= CITY_W'(piv_r + CITY_W'(1));
      hi_r           <= last_idx;
    end
    if (cmd.rev_step) begin
      order_r[lo_r] <= order_r[hi_r];
      order_r[hi_r] <= order_r[lo_r];
      lo_r          <= CITY_W'(lo_r + CITY_W'(1));
      hi_r          <= CITY_W'(hi_r - CITY_W'(1));
    end
    if (cmd.emit) ek_r <= CNT_W'(ek_r + CNT_W'(1));
  end

  // The first tour of a search is always kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (cmd.start_search) begin
      have_best_r <= 1'b0;
    end else if (cmd.edge_acc && keep) begin
      have_best_r <= 1'b1;
    end
  end

  // Result register; the closing city repeats the start of the tour.
  assign e_idx = (ek_r == n_r) ? '0 : CITY_W'(ek_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_city_r    <= CITY_FIELD_W'(best_order_r[e_idx]);
      out_cost_r    <= best_r;
      out_is_last_r <= (ek_r == n_r);
    end
  end

  assign sts.tour_end   = prune || edge_last;
  assign sts.pivot_none = !piv_found;
  assign sts.rev_done   = (lo_r >= hi_r);
  assign sts.emit_last  = (ek_r == n_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_tour_city = out_city_r;
  assign out_best_cost = out_cost_r;
  assign out_is_last   = out_is_last_r;

endmodule

@@ rtl/exhaustive_tour_search_core.sv @@
// ----------------------------------------------------------------------------
// exhaustive_tour_search_core
// Brute-force asymmetric travelling salesman search over a loaded matrix.
// ----------------------------------------------------------------------------
// Each input transfer writes one cost matrix entry. The entry flagged last
// starts a search over every ordering of the n cities in lexicographic
// order. Each summed edge of a tour is a registered matrix read, then a
// saturating add, and a tour stops early once the sum passes the best total.
// Advancing the ordering then finds the pivot, swaps it, swaps the pairs of
// the suffix reversal one by one and closes the reversal, and a full search
// walks all n! orderings. The block then returns n+1 results, the best tour
// closed at its start city. The matrix memory is not cleared and keeps its
// entries between problems.
module exhaustive_tour_search_core #(
  parameter int MAX_CITIES = 8,
  parameter int COST_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  est_in_if.sink                        in_chan,
  est_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [est_pkg::CFG_W-1:0]     cfg_wr_data
);
  import est_pkg::*;

  est_cmd_t         cmd;
  est_sts_t         sts;
  logic             in_ready, in_accept;
  logic [CFG_W-1:0] cfg_num_cities_r;

  // City count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_cities_r <= CFG_W'(8);
    end else if (cfg_wr_en) begin
      cfg_num_cities_r <= cfg_wr_data;
    end
  end

  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  est_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_last   (in_chan.last_entry),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  est_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .COST_BITS  (COST_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .num_cities    (cfg_num_cities_r),
    .wr_en         (in_accept),
    .wr_from       (in_chan.from_city),
    .wr_to         (in_chan.to_city),
    .wr_cost       (in_chan.edge_cost),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_tour_city (out_chan.tour_city),
    .out_best_cost (out_chan.best_cost),
    .out_is_last   (out_chan.is_last)
  );

endmodule

@@ rtl/est_chk.sv @@
// ----------------------------------------------------------------------------
// est_chk
// Port-level checks of the tour search core, bound to the top level.
// ----------------------------------------------------------------------------
module est_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last_entry,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [est_pkg::CITY_FIELD_W-1:0]   out_tour_city,
  input logic                               out_is_last
);

  // A stalled result transfer keeps its city.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tour_city))
    else $error("result changed while stalled");

  // No new item is taken while a result run is still being emitted.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> !in_ready)
    else $error("input ready in the middle of a result run");

  // The final entry starts a search, which closes the input.
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_entry |=> !in_ready)
    else $error("input still ready after the final entry");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind exhaustive_tour_search_core est_chk u_est_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_last_entry (in_chan.last_entry),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_tour_city (out_chan.tour_city),
  .out_is_last   (out_chan.is_last)
);

@@ verif/tb_exhaustive_tour_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exhaustive_tour_search_core
// Loads cost matrices, starts tour searches at several city counts and checks
// every city of each returned tour and its total against a local search that
// walks the orderings the same way, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_exhaustive_tour_search_core;
  import est_pkg::*;

  typedef struct packed {
    logic [CITY_FIELD_W-1:0] city;
    logic [TOTAL_W-1:0]      total;
    logic                    closing;
  } tour_step_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  est_in_if  in_chan();
  est_out_if out_chan();

  exhaustive_tour_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Local copy of the block's state.
  logic signed [EDGE_W-1:0] cost_mat [64];
  bit [63:0]                entry_loaded;
  logic [CFG_W-1:0]         city_reg;
  logic [2:0]               walk_order [8];
  logic [2:0]               kept_order [8];

  tour_step_t tour_q[$];
  int  errors;
  bit  quiet;
  int  hold_req;

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint sat_total(longint v);
    if (v > longint'(TOTAL_MAX)) return longint'(TOTAL_MAX);
    if (v < longint'(TOTAL_MIN)) return longint'(TOTAL_MIN);
    return v;
  endfunction

  // Steps walk_order to the next lexicographic ordering of its first n cities.
  function automatic bit next_ordering(int n);
    int i;
    int j;
    logic [2:0] t;
    i = n - 1;
    while (i > 0 && walk_order[i-1] >= walk_order[i]) i--;
    if (i == 0) return 1'b0;
    j = n - 1;
    while (walk_order[j] <= walk_order[i-1]) j--;
    t = walk_order[i-1]; walk_order[i-1] = walk_order[j]; walk_order[j] = t;
    j = n - 1;
    while (i < j) begin
      t = walk_order[i]; walk_order[i] = walk_order[j]; walk_order[j] = t;
      i++;
      j--;
    end
    return 1'b1;
  endfunction

  function automatic int active_cities();
    if (city_reg < 2) return 2;
    if (city_reg > 8) return 8;
    return int'(city_reg);
  endfunction

  // Searches every ordering, abandoning a tour once its running sum passes
  // the best total, and queues the best tour closed at its start city.
  function automatic void predict_best_tour();
    int n;
    bit have_best;
    bit more;
    longint best;
    longint part;
    tour_step_t step;
    n = active_cities();
    for (int i = 0; i < 8; i++) walk_order[i] = 3'(i);
    best = longint'(TOTAL_MAX);
    have_best = 1'b0;
    more = 1'b1;
    while (more) begin
      part = 0;
      for (int i = 0; i < n; i++) begin
        part = sat_total(part + longint'(cost_mat[walk_order[i]*8 + walk_order[(i+1)%n]]));
        if (have_best && part > best) break;
      end
      if (!have_best || part < best) begin
        have_best = 1'b1;
        best = part;
        kept_order = walk_order;
      end
      more = next_ordering(n);
    end
    for (int k = 0; k <= n; k++) begin
      step.city    = kept_order[k % n];
      step.total   = best[TOTAL_W-1:0];
      step.closing = (k == n);
      tour_q = {tour_q, step};
    end
  endfunction

  function automatic logic [EDGE_W-1:0] pick_cost();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32'h000F_FFFF));
      3:       return -32'($urandom_range(0, 32'h000F_FFFF));
      default: return $urandom;
    endcase
  endfunction

  // Offers one matrix entry and waits for its transfer.
  task automatic send_entry(input logic [2:0] row, input logic [2:0] col,
                            input logic [EDGE_W-1:0] cost, input logic last);
    int gap;
    gap = 0;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.from_city  <= row;
    in_chan.to_city    <= col;
    in_chan.edge_cost  <= cost;
    in_chan.last_entry <= last;
    do @(posedge clk); while (!in_chan.ready);
    cost_mat[row*8 + col] = cost;
    entry_loaded[row*8 + col] = 1'b1;
    if (last) predict_best_tour();
  endtask

  task automatic release_input();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  // Loads every off-diagonal entry of the active problem that has not been written yet.
  task automatic load_missing();
    int n;
    n = active_cities();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (r != c && !entry_loaded[r*8 + c]) send_entry(3'(r), 3'(c), pick_cost(), 1'b0);
  endtask

  task automatic run_search(input logic [2:0] row, input logic [2:0] col);
    load_missing();
    send_entry(row, col, pick_cost(), 1'b1);
  endtask

  // Waits for the outstanding tour, then lets the block settle.
  task automatic wait_drained();
    release_input();
    while (tour_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_city_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    city_reg = value;
  endtask

  // Two cities, with register values below and at the bottom of the legal range and extreme costs.
  task automatic test_two_cities();
    write_city_count(4'd0);
    send_entry(3'd0, 3'd1, 32'h7FFF_FFFF, 1'b0);
    send_entry(3'd1, 3'd0, 32'h8000_0000, 1'b1);
    wait_drained();
    write_city_count(4'd1);
    send_entry(3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0);
    send_entry(3'd1, 3'd0, 32'h7FFF_FFFF, 1'b1);
    wait_drained();
    write_city_count(4'd2);
    send_entry(3'd0, 3'd1, 32'h8000_0000, 1'b1);
    wait_drained();
  endtask

  // Four cities with mixed signs, so that abandoned tours matter.
  task automatic test_small_search();
    write_city_count(4'd4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (r != c) send_entry(3'(r), 3'(c), pick_cost(), 1'b0);
    send_entry(3'd3, 3'd2, 32'hFFFF_0000, 1'b1);
    wait_drained();
  endtask

  // The largest problem, reached through a register value above the range.
  task automatic test_full_eight();
    write_city_count(4'd15);
    run_search(3'd7, 3'd0);
    wait_drained();
  endtask

  // The receiver holds off while further entries keep arriving.
  task automatic test_backpressure();
    write_city_count(4'd3);
    hold_req++;
    run_search(3'd2, 3'd1);
    send_entry(3'd0, 3'd2, pick_cost(), 1'b0);
    send_entry(3'd1, 3'd2, pick_cost(), 1'b1);
    send_entry(3'd2, 3'd0, pick_cost(), 1'b1);
    wait_drained();
  endtask

  // Random problems at small city counts; the last part runs without idling.
  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 43) begin
      if (sent > 33) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
        write_city_count(4'($urandom_range(0, 5)));
      end
      if ($urandom_range(0, 4) == 0) begin
        run_search(3'($urandom), 3'($urandom));
      end else begin
        send_entry(3'($urandom), 3'($urandom), pick_cost(), 1'b0);
      end
      sent++;
    end
    wait_drained();
  endtask

  // Result side: random stalls, plus the long hold-off when one is asked for.
  int stall_left;
  int hold_left;
  int hold_seen;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Compares each result transfer with the oldest expected tour city.
  always @(posedge clk) begin
    tour_step_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (tour_q.size() == 0) begin
        $error("unexpected result: city %0d total %0d", out_chan.tour_city,
               out_chan.best_cost);
        errors++;
      end else begin
        want = tour_q.pop_front();
        if (out_chan.tour_city !== want.city) begin
          $error("tour_city: expected %0d, got %0d", want.city, out_chan.tour_city);
          errors++;
        end
        if (out_chan.best_cost !== want.total) begin
          $error("best_cost: expected %0d, got %0d", $signed(want.total),
                 out_chan.best_cost);
          errors++;
        end
        if (out_chan.is_last !== want.closing) begin
          $error("is_last: expected %0b, got %0b", want.closing, out_chan.is_last);
          errors++;
        end
      end
    end
  end

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.from_city  = '0;
    in_chan.to_city    = '0;
    in_chan.edge_cost  = '0;
    in_chan.last_entry = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    rst_n              = 1'b0;
    quiet              = 1'b0;
    hold_req           = 0;
    entry_loaded       = '0;
    city_reg           = 4'd8;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_two_cities();
    test_small_search();
    test_full_eight();
    test_backpressure();
    test_random();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ exhaustive_tour_search_core.f @@
rtl/est_pkg.sv
rtl/est_in_if.sv
rtl/est_out_if.sv
rtl/est_ctrl.sv
rtl/est_dpath.sv
rtl/exhaustive_tour_search_core.sv
rtl/est_chk.sv
verif/tb_exhaustive_tour_search_core.sv
